[hw/rtl/text_console_cursor_scroll_assert.svh]
// ----------------------------------------------------------------------------
// text console assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// condition holds at every edge out of reset
`define TCCS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tccs: invariant violated");

// same-cycle implication
`define TCCS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tccs: implication violated");

// next-cycle implication
`define TCCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tccs: sequence violated");

`endif

[hw/rtl/tccs_pkg.sv]
// ----------------------------------------------------------------------------
// tccs_pkg
// types, geometry constants and character codes of the text console
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int unsigned COLUMNS   = 80;
	localparam int unsigned ROWS      = 25;
	localparam int unsigned TAB_WIDTH = 8;   // power of two
	localparam int unsigned CELLS     = ROWS * COLUMNS;

	localparam int unsigned ROW_W  = $clog2(ROWS);
	localparam int unsigned COL_W  = $clog2(COLUMNS);
	localparam int unsigned ADDR_W = $clog2(CELLS);

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ROW_W:0]    rowx_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [COL_W:0]    colx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [4:0]        frow_t;
	typedef logic [6:0]        fcol_t;

	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] RESET_COLOR = 8'd15;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
		frow_t      read_row;
		fcol_t      read_col;
	} req_word_t;

	typedef struct packed {
		logic [15:0] cell_value;
		frow_t       cursor_row;
		fcol_t       cursor_col;
		logic        scrolled;
	} rsp_word_t;

	typedef struct packed {
		row_t row;
		col_t col;
		logic scroll;
		logic write;
	} cursor_step_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLANK,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/text_console_cursor_scroll.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text console screen memory with cursor, wrap and one-line scroll
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | tccs_pkg::req_word_t
//   rsp     | out       | rsp_valid/rsp_ready  | tccs_pkg::rsp_word_t
//   cfg     | in        | cfg_valid/cfg_ready  | text color, 8 bits
//
// a read or an ordinary put is accepted together with its memory access, then
// its result is loaded into the output register; one memory port each for read/write
// a put that scrolls first blanks one row, one cell per step; the screen is a
// ring of rows, so a scroll moves the top-row pointer and copies nothing
// after reset a clearing pass writes all ROWS*COLUMNS cells, one per cycle,
// before the first word is taken; cfg writes are taken at any time
// a full output register holds the finished result until rsp_ready
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_assert.svh"

module text_console_cursor_scroll (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tccs_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tccs_pkg::rsp_word_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	function automatic tccs_pkg::row_t phys_row(tccs_pkg::row_t lrow, tccs_pkg::row_t top);
		tccs_pkg::rowx_t s;
		s = tccs_pkg::rowx_t'(lrow) + tccs_pkg::rowx_t'(top);
		if (32'(s) >= tccs_pkg::ROWS)
			s = s - tccs_pkg::rowx_t'(tccs_pkg::ROWS);
		return tccs_pkg::row_t'(s);
	endfunction

	function automatic tccs_pkg::addr_t cell_addr(tccs_pkg::row_t prow, tccs_pkg::col_t col);
		return tccs_pkg::addr_t'(32'(prow) * tccs_pkg::COLUMNS + 32'(col));
	endfunction

	tccs_pkg::state_t       state_q, state_nx;
	tccs_pkg::row_t         row_q, top_q;
	tccs_pkg::col_t         col_q, blank_col_q;
	tccs_pkg::addr_t        clr_addr_q, blank_base_s1;
	logic [7:0]             color_q;
	logic                   scrolled_s1, rd_hit_s1;
	logic                   rsp_valid_q;
	tccs_pkg::rsp_word_t    rsp_q;
	tccs_pkg::cursor_step_t step;

	logic [15:0]     mem [tccs_pkg::CELLS];
	logic [15:0]     rd_data_q;
	logic            mem_we, mem_re;
	tccs_pkg::addr_t mem_waddr, mem_raddr;
	logic [15:0]     mem_wdata;

	logic req_acc, is_put, rd_in_range, rsp_load;

	tccs_cursor u_cursor (
		.char_code (req.char_code),
		.row       (row_q),
		.col       (col_q),
		.step      (step)
	);

	assign req_ready   = (state_q == tccs_pkg::ST_IDLE);
	assign req_acc     = req_valid && req_ready;
	assign is_put      = (req.kind == tccs_pkg::KIND_PUT);
	assign rd_in_range = (32'(req.read_row) < tccs_pkg::ROWS)
		&& (32'(req.read_col) < tccs_pkg::COLUMNS);
	assign rsp_load    = (state_q == tccs_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign cfg_ready   = 1'b1;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tccs_pkg::ST_CLEAR: begin
				if (clr_addr_q == tccs_pkg::addr_t'(tccs_pkg::CELLS - 1))
					state_nx = tccs_pkg::ST_IDLE;
			end
			tccs_pkg::ST_IDLE: begin
				if (req_acc)
					state_nx = (is_put && step.scroll) ? tccs_pkg::ST_BLANK : tccs_pkg::ST_DONE;
			end
			tccs_pkg::ST_BLANK: begin
				if (blank_col_q == tccs_pkg::col_t'(tccs_pkg::COLUMNS - 1))
					state_nx = tccs_pkg::ST_DONE;
			end
			tccs_pkg::ST_DONE: begin
				if (rsp_load)
					state_nx = tccs_pkg::ST_IDLE;
			end
			default: state_nx = tccs_pkg::ST_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(phys_row(row_q, top_q), col_q);
		mem_wdata = {color_q, req.char_code};
		mem_re    = req_acc && !is_put && rd_in_range;
		mem_raddr = cell_addr(phys_row(tccs_pkg::row_t'(req.read_row), top_q),
			tccs_pkg::col_t'(req.read_col));
		unique case (state_q)
			tccs_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = {tccs_pkg::RESET_COLOR, tccs_pkg::CH_SPACE};
			end
			tccs_pkg::ST_IDLE: begin
				mem_we = req_acc && is_put && step.write;
			end
			tccs_pkg::ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = blank_base_s1 + tccs_pkg::addr_t'(blank_col_q);
				mem_wdata = {color_q, tccs_pkg::CH_SPACE};
			end
			tccs_pkg::ST_DONE: begin
				mem_we = 1'b0;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccs_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			blank_col_q <= '0;
			color_q     <= tccs_pkg::RESET_COLOR;
			scrolled_s1 <= 1'b0;
			rd_hit_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready)
				color_q <= cfg_data;
			if (state_q == tccs_pkg::ST_CLEAR)
				clr_addr_q <= clr_addr_q + tccs_pkg::addr_t'(1);
			if (state_q == tccs_pkg::ST_BLANK)
				blank_col_q <= blank_col_q + tccs_pkg::col_t'(1);
			if (req_acc) begin
				scrolled_s1 <= is_put && step.scroll;
				rd_hit_s1   <= !is_put && rd_in_range;
				if (is_put) begin
					row_q <= step.row;
					col_q <= step.col;
					if (step.scroll) begin
						blank_col_q <= '0;
						if (top_q == tccs_pkg::row_t'(tccs_pkg::ROWS - 1))
							top_q <= '0;
						else
							top_q <= top_q + tccs_pkg::row_t'(1);
					end
				end
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc)
			blank_base_s1 <= cell_addr(top_q, '0);
		if (rsp_load) begin
			rsp_q.cell_value <= rd_hit_s1 ? rd_data_q : 16'h0000;
			rsp_q.cursor_row <= tccs_pkg::frow_t'(row_q);
			rsp_q.cursor_col <= tccs_pkg::fcol_t'(col_q);
			rsp_q.scrolled   <= scrolled_s1;
		end
	end

	`TCCS_ASSERT_ALWAYS(a_cursor_row_range, 32'(row_q) < tccs_pkg::ROWS)
	`TCCS_ASSERT_ALWAYS(a_cursor_col_range, 32'(col_q) < tccs_pkg::COLUMNS)
	`TCCS_ASSERT_ALWAYS(a_top_row_range, 32'(top_q) < tccs_pkg::ROWS)
	`TCCS_ASSERT_IMPLY(a_no_write_in_done, state_q == tccs_pkg::ST_DONE, !mem_we)
	`TCCS_ASSERT_IMPLY(a_scroll_on_last_row, (state_q == tccs_pkg::ST_DONE) && scrolled_s1, 32'(row_q) == tccs_pkg::ROWS - 1)
	`TCCS_ASSERT_NEXT(a_accept_leaves_idle, req_acc, (state_q == tccs_pkg::ST_DONE) || (state_q == tccs_pkg::ST_BLANK))

endmodule

[hw/rtl/tccs_cursor.sv]
// ----------------------------------------------------------------------------
// tccs_cursor
// next cursor position for one put: newline, tab stop, glyph advance, wrap
// ----------------------------------------------------------------------------
module tccs_cursor (
	input  logic [7:0]             char_code,
	input  tccs_pkg::row_t         row,
	input  tccs_pkg::col_t         col,
	output tccs_pkg::cursor_step_t step
);

	tccs_pkg::colx_t c1;
	tccs_pkg::rowx_t r1;

	always_comb begin
		step.write = 1'b0;
		if (char_code == tccs_pkg::CH_NEWLINE) begin
			c1 = '0;
			r1 = tccs_pkg::rowx_t'(row) + tccs_pkg::rowx_t'(1);
		end else if (char_code == tccs_pkg::CH_TAB) begin
			c1 = (tccs_pkg::colx_t'(col) | tccs_pkg::colx_t'(tccs_pkg::TAB_WIDTH - 1))
				+ tccs_pkg::colx_t'(1);
			r1 = tccs_pkg::rowx_t'(row);
		end else begin
			c1 = tccs_pkg::colx_t'(col) + tccs_pkg::colx_t'(1);
			r1 = tccs_pkg::rowx_t'(row);
			step.write = 1'b1;
		end
		// wrap past the right edge
		if (32'(c1) >= tccs_pkg::COLUMNS) begin
			c1 = '0;
			r1 = r1 + tccs_pkg::rowx_t'(1);
		end
		// scroll past the bottom
		if (32'(r1) >= tccs_pkg::ROWS) begin
			step.scroll = 1'b1;
			step.row    = tccs_pkg::row_t'(tccs_pkg::ROWS - 1);
		end else begin
			step.scroll = 1'b0;
			step.row    = tccs_pkg::row_t'(r1);
		end
		step.col = tccs_pkg::col_t'(c1);
	end

endmodule

[sim/text_console_cursor_scroll_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// drives put and read words through the console under random sender gaps and
// receiver stalls, keeps its own screen, cursor and color, and checks every
// result word field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;

	localparam int unsigned DRAIN_LIMIT  = 5000;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_WORDS  = 90;
	localparam int unsigned PRINT_LIMIT  = 40;

	typedef enum int unsigned {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_LONG
	} rx_mode_t;

	class console_scoreboard;
		logic [15:0]         screen [tccs_pkg::CELLS];
		int unsigned         cur_row;
		int unsigned         cur_col;
		logic [7:0]          color;
		tccs_pkg::rsp_word_t pending [$];
		int unsigned         errors;
		int unsigned         n_checked;
		int unsigned         n_put;
		int unsigned         n_read;
		int unsigned         n_read_oob;
		int unsigned         n_scroll;
		int unsigned         n_wrap;
		int unsigned         n_color;

		function new();
			foreach (screen[i]) screen[i] = {tccs_pkg::RESET_COLOR, tccs_pkg::CH_SPACE};
			cur_row = 0;
			cur_col = 0;
			color = tccs_pkg::RESET_COLOR;
		endfunction

		function void set_color(logic [7:0] c);
			color = c;
			n_color++;
		endfunction

		function void scroll_up();
			for (int unsigned i = 0; i < (tccs_pkg::ROWS - 1) * tccs_pkg::COLUMNS; i++)
				screen[i] = screen[i + tccs_pkg::COLUMNS];
			for (int unsigned i = (tccs_pkg::ROWS - 1) * tccs_pkg::COLUMNS;
				i < tccs_pkg::CELLS; i++)
				screen[i] = {color, tccs_pkg::CH_SPACE};
		endfunction

		function void note_request(tccs_pkg::req_word_t w);
			tccs_pkg::rsp_word_t want;
			want = '0;
			if (w.kind == tccs_pkg::KIND_READ) begin
				n_read++;
				if (w.read_row < tccs_pkg::ROWS && w.read_col < tccs_pkg::COLUMNS) begin
					want.cell_value = screen[w.read_row * tccs_pkg::COLUMNS + w.read_col];
				end else begin
					n_read_oob++;
				end
			end else begin
				n_put++;
				if (w.char_code == tccs_pkg::CH_NEWLINE) begin
					cur_col = 0;
					cur_row++;
				end else if (w.char_code == tccs_pkg::CH_TAB) begin
					cur_col = (cur_col + tccs_pkg::TAB_WIDTH) / tccs_pkg::TAB_WIDTH
						* tccs_pkg::TAB_WIDTH;
				end else begin
					screen[cur_row * tccs_pkg::COLUMNS + cur_col] = {color, w.char_code};
					cur_col++;
				end
				if (cur_col >= tccs_pkg::COLUMNS) begin
					cur_col = 0;
					cur_row++;
					n_wrap++;
				end
				if (cur_row >= tccs_pkg::ROWS) begin
					scroll_up();
					cur_row = tccs_pkg::ROWS - 1;
					want.scrolled = 1'b1;
					n_scroll++;
				end
			end
			want.cursor_row = tccs_pkg::frow_t'(cur_row);
			want.cursor_col = tccs_pkg::fcol_t'(cur_col);
			pending.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t tccs check: %s", $time, msg);
		endtask

		task check_result(tccs_pkg::rsp_word_t got);
			tccs_pkg::rsp_word_t want;
			if (pending.size() == 0) begin
				report($sformatf("result word %h with nothing pending", got));
			end else begin
				want = pending.pop_front();
				n_checked++;
				if (got.cell_value !== want.cell_value)
					report($sformatf("cell_value %h, want %h", got.cell_value, want.cell_value));
				if (got.cursor_row !== want.cursor_row)
					report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
				if (got.cursor_col !== want.cursor_col)
					report($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
				if (got.scrolled !== want.scrolled)
					report($sformatf("scrolled %b, want %b", got.scrolled, want.scrolled));
			end
		endtask

		task close_out();
			if (pending.size() != 0)
				report($sformatf("%0d result words never arrived", pending.size()));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	tccs_pkg::req_word_t req;
	logic                rsp_valid;
	logic                rsp_ready;
	tccs_pkg::rsp_word_t rsp;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;

	console_scoreboard sb = new();

	text_console_cursor_scroll DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result words are checked at the edge that takes them
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	// receiver stall pattern
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_hold = 0;
	int unsigned rx_tick = 0;
	logic        rx_long_ready = 1'b1;

	always @(negedge clk) begin
		rx_tick++;
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(64, 256);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: rsp_ready <= 1'b1;
			RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: rsp_ready <= (rx_tick % 5) < 3;
			default: begin
				if (rx_hold == 0) begin
					rx_long_ready = ~rx_long_ready;
					rx_hold = rx_long_ready ? $urandom_range(1, 6) : $urandom_range(5, 20);
				end
				rx_hold--;
				rsp_ready <= rx_long_ready;
			end
		endcase
	end

	task automatic send_word(input tccs_pkg::req_word_t w);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(w);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int unsigned n);
		req_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		req_valid <= 1'b0;
		while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (tccs_pkg::COLUMNS + 8) @(negedge clk);
	endtask

	task automatic write_color(input logic [7:0] c);
		cfg_data <= c;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_color(c);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic tccs_pkg::req_word_t put_word(input logic [7:0] ch);
		tccs_pkg::req_word_t w;
		w.kind = tccs_pkg::KIND_PUT;
		w.char_code = ch;
		w.read_row = tccs_pkg::frow_t'($urandom_range(0, 31));
		w.read_col = tccs_pkg::fcol_t'($urandom_range(0, 127));
		return w;
	endfunction

	function automatic tccs_pkg::req_word_t read_word(input int unsigned r,
		input int unsigned c);
		tccs_pkg::req_word_t w;
		w.kind = tccs_pkg::KIND_READ;
		w.char_code = 8'($urandom_range(0, 255));
		w.read_row = tccs_pkg::frow_t'(r);
		w.read_col = tccs_pkg::fcol_t'(c);
		return w;
	endfunction

	function automatic tccs_pkg::req_word_t random_word();
		int unsigned sel;
		int unsigned r;
		int unsigned c;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			sel = $urandom_range(0, 9);
			if (sel < 3) r = sb.cur_row;
			else if (sel < 5) r = tccs_pkg::ROWS - 1;
			else if (sel < 8) r = $urandom_range(0, tccs_pkg::ROWS - 1);
			else r = $urandom_range(0, 31);
			c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, tccs_pkg::COLUMNS - 1)
			                                : $urandom_range(0, 127);
			return read_word(r, c);
		end
		if (sel < 43) return put_word(tccs_pkg::CH_NEWLINE);
		if (sel < 51) return put_word(tccs_pkg::CH_TAB);
		if (sel < 66) return put_word(8'($urandom_range(0, 255)));
		return put_word(8'($urandom_range(33, 126)));
	endfunction

	logic [7:0] phase_color [PHASES];

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// screen corners, off-screen reads, odd glyphs, tab run to the right edge
		send_word(read_word(0, 0));
		send_word(read_word(tccs_pkg::ROWS - 1, tccs_pkg::COLUMNS - 1));
		send_word(read_word(tccs_pkg::ROWS, 0));
		send_word(read_word(31, 127));
		send_word(read_word(0, tccs_pkg::COLUMNS));
		send_word(put_word(8'h00));
		send_word(put_word(8'hFF));
		send_word(put_word("A"));
		send_word(put_word(tccs_pkg::CH_TAB));
		send_word(put_word(tccs_pkg::CH_NEWLINE));
		repeat (tccs_pkg::COLUMNS / tccs_pkg::TAB_WIDTH) send_word(put_word(tccs_pkg::CH_TAB));
		send_word(read_word(0, 0));
		send_word(read_word(0, 1));
		send_word(read_word(0, 2));

		phase_color[0] = tccs_pkg::RESET_COLOR;
		phase_color[1] = 8'h00;
		phase_color[2] = 8'hFF;
		phase_color[3] = 8'($urandom_range(0, 255));
		phase_color[4] = 8'h4E;
		phase_color[5] = 8'($urandom_range(0, 255));

		for (int unsigned p = 0; p < PHASES; p++) begin
			int unsigned sent;
			int unsigned burst;
			if (p != 0) begin
				drain_results();
				write_color(phase_color[p]);
			end
			sent = 0;
			while (sent < PHASE_WORDS) begin
				burst = $urandom_range(1, 24);
				for (int unsigned k = 0; k < burst && sent < PHASE_WORDS; k++) begin
					send_word(random_word());
					sent++;
				end
				if ($urandom_range(0, 30) == 0)
					drain_results();
				else if (p % 3 != 1)
					idle_sender($urandom_range(1, 8));
			end
		end

		drain_results();
		sb.close_out();
		$display("sent %0d puts (%0d scrolls, %0d line wraps) and %0d reads (%0d off-screen)",
			sb.n_put, sb.n_scroll, sb.n_wrap, sb.n_read, sb.n_read_oob);
		$display("%0d color settings, %0d result words checked, %0d errors",
			sb.n_color, sb.n_checked, sb.errors);
		if (sb.errors == 0)
			$display("text_console_cursor_scroll: match");
		else
			$display("text_console_cursor_scroll: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("text_console_cursor_scroll: mismatch");
		$finish;
	end

endmodule
